// ===== hdl/bptc_pkg.sv =====
// Package with constants, register codes and helper functions for the baro compensation unit.
`timescale 1ns / 1ps

package bptc_pkg;

	// Raw samples and fixed scale.
	localparam int unsigned RAW_W        = 24;
	localparam int unsigned SCALE_FACTOR = 7864320;
	localparam int unsigned SCALE_DIV    = SCALE_FACTOR >> 16;

	// The scale splits into a power of two and an odd part; the odd part is
	// divided by a reciprocal multiplication.
	localparam int unsigned PRE_SHIFT    = 3;
	localparam int unsigned DIV_ODD      = SCALE_DIV >> PRE_SHIFT;
	localparam int unsigned RECIP_SHIFT  = 25;
	localparam int unsigned RECIP_M      = ((1 << RECIP_SHIFT) + DIV_ODD - 1) / DIV_ODD;
	localparam int unsigned RECIP_W      = 22;

	localparam int unsigned MAG_W        = RAW_W - PRE_SHIFT;   // magnitude after pre-shift
	localparam int unsigned PROD_W       = MAG_W + RECIP_W;
	localparam int unsigned Q_W          = 17;                  // quotient magnitude
	localparam int unsigned SC_W         = Q_W + 1;             // signed scaled sample

	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned CFG_DATA_W   = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_COEFS   = 3'd0,
		REG_PRESS_OFFSET = 3'd1,
		REG_PRESS_LIN    = 3'd2,
		REG_TEMP_CROSS   = 3'd3,
		REG_CROSS_LIN    = 3'd4,
		REG_PRESS_QUAD   = 3'd5,
		REG_CROSS_QUAD   = 3'd6,
		REG_PRESS_CUBIC  = 3'd7
	} cfg_reg_t;

	// Arithmetic shift right by 16 of a 32-bit word.
	function automatic logic [31:0] asr16(input logic [31:0] x);
		return {{16{x[31]}}, x[31:16]};
	endfunction

	function automatic logic [31:0] sext12(input logic [11:0] x);
		return {{20{x[11]}}, x};
	endfunction

	function automatic logic [31:0] sext16(input logic [15:0] x);
		return {{16{x[15]}}, x};
	endfunction

	function automatic logic [31:0] sext20(input logic [19:0] x);
		return {{12{x[19]}}, x};
	endfunction

	function automatic logic [31:0] sext_sc(input logic [SC_W-1:0] x);
		return {{(32 - SC_W){x[SC_W-1]}}, x};
	endfunction

endpackage

// ===== hdl/baro_pressure_temp_compensate_unit.sv =====
// Top level of the barometric pressure and temperature compensation pipeline.
`timescale 1ns / 1ps

// The unit takes one raw pressure and temperature sample pair per clock cycle and returns
// the compensated pressure and the Q16 temperature through a registered pipeline.
// The nine-stage pipeline is split as follows: three stages scale the samples by the fixed
// divisor of 120, and the Horner chain of the pressure polynomial needs three multiplier
// stages, each followed by a shift-and-add stage. Busy is always low, so an item may be
// offered in every cycle; the result appears on press_comp and temp_q16 for exactly one
// cycle with done high, and the receiver must take it then, because nothing holds it.
// The calibration registers are written over the cfg channel, which is always ready; they
// must only be changed while no item is in flight, since stages 4, 5, 7 and 9 read them directly.
module baro_pressure_temp_compensate_unit
	import bptc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Sample input.
	input  logic                  start,
	output logic                  busy,
	input  logic signed [23:0]    raw_press,
	input  logic signed [23:0]    raw_temp,
	// Result output, valid for one cycle while done is high.
	output logic                  done,
	output logic [31:0]           press_comp,
	output logic signed [31:0]    temp_q16,
	// Configuration write channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// ------------------------------------------------------------------
	// Calibration registers. Each one keeps only its own width.
	// ------------------------------------------------------------------
	logic [23:0] temp_coefs_q;
	logic [19:0] press_offset_q;
	logic [19:0] press_lin_q;
	logic [15:0] temp_cross_q;
	logic [15:0] cross_lin_q;
	logic [15:0] press_quad_q;
	logic [15:0] cross_quad_q;
	logic [15:0] press_cubic_q;

	logic cfg_we;
	logic accept;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;
	assign busy      = 1'b0;
	assign accept    = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coefs_q   <= '0;
			press_offset_q <= '0;
			press_lin_q    <= '0;
			temp_cross_q   <= '0;
			cross_lin_q    <= '0;
			press_quad_q   <= '0;
			cross_quad_q   <= '0;
			press_cubic_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TEMP_COEFS:   temp_coefs_q   <= cfg_data[23:0];
				REG_PRESS_OFFSET: press_offset_q <= cfg_data[19:0];
				REG_PRESS_LIN:    press_lin_q    <= cfg_data[19:0];
				REG_TEMP_CROSS:   temp_cross_q   <= cfg_data[15:0];
				REG_CROSS_LIN:    cross_lin_q    <= cfg_data[15:0];
				REG_PRESS_QUAD:   press_quad_q   <= cfg_data[15:0];
				REG_CROSS_QUAD:   cross_quad_q   <= cfg_data[15:0];
				REG_PRESS_CUBIC:  press_cubic_q  <= cfg_data[15:0];
				default:          press_cubic_q  <= cfg_data[15:0];
			endcase
		end
	end

	// Sign-extended coefficients, as 32-bit patterns.
	logic [31:0] c0, c1, c00, c10, c01, c11, c20, c21, c30;

	assign c0  = sext12(temp_coefs_q[23:12]);
	assign c1  = sext12(temp_coefs_q[11:0]);
	assign c00 = sext20(press_offset_q);
	assign c10 = sext20(press_lin_q);
	assign c01 = sext16(temp_cross_q);
	assign c11 = sext16(cross_lin_q);
	assign c20 = sext16(press_quad_q);
	assign c21 = sext16(cross_quad_q);
	assign c30 = sext16(press_cubic_q);

	// ------------------------------------------------------------------
	// Valid bits. The receiver cannot stall, so the pipeline always moves.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: magnitude and sign of each sample, with the power-of-two part
	// of the divisor shifted out. Flooring by 8 and then by 15 equals
	// flooring by 120.
	// ------------------------------------------------------------------
	logic [RAW_W-1:0] p_abs, t_abs;
	logic [MAG_W-1:0] p_mag_s1, t_mag_s1;
	logic             p_neg_s1, t_neg_s1;

	assign p_abs = raw_press[RAW_W-1] ? (~raw_press + 1'b1) : raw_press;
	assign t_abs = raw_temp[RAW_W-1]  ? (~raw_temp + 1'b1)  : raw_temp;

	always_ff @(posedge clk) begin
		p_mag_s1 <= p_abs[RAW_W-1:PRE_SHIFT];
		t_mag_s1 <= t_abs[RAW_W-1:PRE_SHIFT];
		p_neg_s1 <= raw_press[RAW_W-1];
		t_neg_s1 <= raw_temp[RAW_W-1];
	end

	// ------------------------------------------------------------------
	// Stage 2: division of the magnitude by the odd part through a
	// reciprocal multiplication. The rounding error of the reciprocal stays
	// below one unit over the whole magnitude range, so no correction step
	// is needed.
	// ------------------------------------------------------------------
	logic [PROD_W-1:0] p_recip, t_recip;
	logic [Q_W-1:0]    p_quo_s2, t_quo_s2;
	logic              p_neg_s2, t_neg_s2;

	assign p_recip = PROD_W'(p_mag_s1) * PROD_W'(RECIP_M);
	assign t_recip = PROD_W'(t_mag_s1) * PROD_W'(RECIP_M);

	always_ff @(posedge clk) begin
		p_quo_s2 <= p_recip[RECIP_SHIFT +: Q_W];
		t_quo_s2 <= t_recip[RECIP_SHIFT +: Q_W];
		p_neg_s2 <= p_neg_s1;
		t_neg_s2 <= t_neg_s1;
	end

	// ------------------------------------------------------------------
	// Stage 3: the sign goes back on, which truncates toward zero.
	// ------------------------------------------------------------------
	logic [SC_W-1:0] psc_s3, tsc_s3;

	always_ff @(posedge clk) begin
		psc_s3 <= p_neg_s2 ? (SC_W'(0) - {1'b0, p_quo_s2}) : {1'b0, p_quo_s2};
		tsc_s3 <= t_neg_s2 ? (SC_W'(0) - {1'b0, t_quo_s2}) : {1'b0, t_quo_s2};
	end

	// ------------------------------------------------------------------
	// Stage 4: the first products, all kept to their low 32 bits.
	// ------------------------------------------------------------------
	logic [31:0] psc32_s3, tsc32_s3;
	logic [31:0] pa1_s4, pb1_s4, pt_s4, ptm_s4;
	logic [SC_W-1:0] psc_s4, tsc_s4;

	assign psc32_s3 = sext_sc(psc_s3);
	assign tsc32_s3 = sext_sc(tsc_s3);

	always_ff @(posedge clk) begin
		pa1_s4 <= psc32_s3 * c30;
		pb1_s4 <= psc32_s3 * c21;
		pt_s4  <= tsc32_s3 * c01;
		ptm_s4 <= tsc32_s3 * c1;
		psc_s4 <= psc_s3;
		tsc_s4 <= tsc_s3;
	end

	// ------------------------------------------------------------------
	// Stage 5: shift and add. Temperature is finished here.
	// ------------------------------------------------------------------
	logic [31:0] a1_s5, b1_s5, t_s5, temp_s5;
	logic [SC_W-1:0] psc_s5, tsc_s5;

	always_ff @(posedge clk) begin
		a1_s5   <= asr16(pa1_s4) + c20;
		b1_s5   <= asr16(pb1_s4) + c11;
		t_s5    <= asr16(pt_s4);
		temp_s5 <= {c0[16:0], 15'd0} + ptm_s4;
		psc_s5  <= psc_s4;
		tsc_s5  <= tsc_s4;
	end

	// ------------------------------------------------------------------
	// Stage 6: second Horner products.
	// ------------------------------------------------------------------
	logic [31:0] pa2_s6, pb2_s6, t_s6, temp_s6;
	logic [SC_W-1:0] psc_s6, tsc_s6;

	always_ff @(posedge clk) begin
		pa2_s6  <= sext_sc(psc_s5) * a1_s5;
		pb2_s6  <= sext_sc(psc_s5) * b1_s5;
		t_s6    <= t_s5;
		temp_s6 <= temp_s5;
		psc_s6  <= psc_s5;
		tsc_s6  <= tsc_s5;
	end

	// ------------------------------------------------------------------
	// Stage 7: shift and add.
	// ------------------------------------------------------------------
	logic [31:0] a2_s7, b2_s7, t_s7, temp_s7;
	logic [SC_W-1:0] psc_s7, tsc_s7;

	always_ff @(posedge clk) begin
		a2_s7   <= asr16(pa2_s6) + c10;
		b2_s7   <= asr16(pb2_s6);
		t_s7    <= t_s6;
		temp_s7 <= temp_s6;
		psc_s7  <= psc_s6;
		tsc_s7  <= tsc_s6;
	end

	// ------------------------------------------------------------------
	// Stage 8: last products. The cross branch ends with the temperature.
	// ------------------------------------------------------------------
	logic [31:0] pq2_s8, pq3_s8, t_s8, temp_s8;

	always_ff @(posedge clk) begin
		pq2_s8  <= sext_sc(psc_s7) * a2_s7;
		pq3_s8  <= sext_sc(tsc_s7) * b2_s7;
		t_s8    <= t_s7;
		temp_s8 <= temp_s7;
	end

	// ------------------------------------------------------------------
	// Stage 9: final sum into the output registers.
	// ------------------------------------------------------------------
	logic [31:0] press_s9, temp_s9;

	always_ff @(posedge clk) begin
		press_s9 <= t_s8 + asr16(pq3_s8) + c00 + asr16(pq2_s8);
		temp_s9  <= temp_s8;
	end

	assign done       = v_s9;
	assign press_comp = press_s9;
	assign temp_q16   = temp_s9;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##9 done)
		else $error("accepted item did not produce a result after nine cycles");

	a_result_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 9))
		else $error("result strobe without an item accepted nine cycles earlier");

	a_cfg_temp_written: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == REG_TEMP_COEFS) |=> temp_coefs_q == $past(cfg_data[23:0]))
		else $error("temperature coefficient write was not taken");

endmodule
